/* design/ose_pkg.sv */
// Shared types and constants for the ordered set engine.
package ose_pkg;

    localparam int KEY_W        = 64;
    localparam int FUNC_W       = 3;
    localparam int CNT_OUT_W    = 7;
    localparam int DEF_CAPACITY = 64;

    localparam logic [FUNC_W-1:0] FUNC_INSERT   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CONTAINS = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_MIN      = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_MAX      = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd5;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             capture;   // register compare flags against cmp_key
        logic             ins_en;    // apply an insert of wr_key
        logic             rem_en;    // apply a remove of wr_key
        logic [KEY_W-1:0] cmp_key;
        logic [KEY_W-1:0] wr_key;
    } cell_ctrl_t;

    // per-cell compare status, registered at capture
    typedef struct packed {
        logic below;   // occupied and entry < key
        logic ge;      // occupied and entry >= key
        logic match;   // occupied and entry == key
        logic tail;    // last occupied cell
    } cell_flags_t;

endpackage

/* design/ose_cell.sv */
// One cell of the sorted row: holds one entry, compares it, shifts with neighbors.
module ose_cell
    import ose_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 7
)
(
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  logic [CW-1:0]    count,
    input  logic [KEY_W-1:0] left_entry,
    input  cell_flags_t      left_flags,
    input  logic [KEY_W-1:0] right_entry,
    output logic [KEY_W-1:0] entry,
    output cell_flags_t      flags,
    output logic [KEY_W-1:0] tail_value
);

    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

    logic [KEY_W-1:0] entry_reg;
    logic [KEY_W-1:0] entry_next;
    cell_flags_t      flags_reg;
    cell_flags_t      flags_next;
    logic             occupied;

    assign occupied = (IDX_C < count);

    always_comb
    begin
        flags_next       = flags_reg;
        if (ctrl.capture)
        begin
            flags_next.below = occupied && (entry_reg < ctrl.cmp_key);
            flags_next.ge    = occupied && !(entry_reg < ctrl.cmp_key);
            flags_next.match = occupied && (entry_reg == ctrl.cmp_key);
            flags_next.tail  = (IDX_P1 == count);
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en)
        begin
            // new key lands at the first cell not below it; higher cells move up
            if (!flags_reg.below && left_flags.below)
            begin
                entry_next = ctrl.wr_key;
            end
            else if (left_flags.ge)
            begin
                entry_next = left_entry;
            end
        end
        else if (ctrl.rem_en)
        begin
            if (flags_reg.ge)
            begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        flags_reg <= flags_next;
    end

    assign entry      = entry_reg;
    assign flags      = flags_reg;
    assign tail_value = flags_reg.tail ? entry_reg : '0;

endmodule

/* design/ordered_set_engine.sv */
// Ordered set engine top level: request control, cell row and result register.
// Request accept captures the compare flags; EVAL then commits the update and loads the response.
// A new request is accepted only in IDLE, once the previous one has committed; the commit
//   waits if the previous response has not been taken.
// Reset (rst_n, async, active low) empties the set and drops any pending
//   response; the cell contents are not cleared and are never read while empty.
module ordered_set_engine
    import ose_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [FUNC_W-1:0]    func,
    input  logic [KEY_W-1:0]     key,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic                 hit,
    output logic [KEY_W-1:0]     result_value,
    output logic [CNT_OUT_W-1:0] entry_count,
    output logic                 full_error,
    output logic                 empty_error
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // one-hot sequencer: IDLE takes a request and captures compare flags,
    // EVAL commits the row update and loads the response register
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [FUNC_W-1:0]   func_reg;
    logic [KEY_W-1:0]    key_reg;

    logic                rsp_valid_reg, rsp_valid_next;
    logic                hit_reg, hit_next;
    logic [KEY_W-1:0]    value_reg, value_next;
    logic [CW-1:0]       rcount_reg, rcount_next;
    logic                full_err_reg, full_err_next;
    logic                empty_err_reg, empty_err_next;

    logic                req_fire;
    logic                commit;
    logic                found;
    logic                is_full;
    logic                is_empty;
    logic                do_ins;
    logic                do_rem;
    logic [KEY_W-1:0]    tail_or;

    cell_ctrl_t          cell_ctrl;
    logic [KEY_W-1:0]    entries   [CAPACITY];
    cell_flags_t         cflags    [CAPACITY];
    logic [KEY_W-1:0]    tail_vals [CAPACITY];
    logic [CAPACITY-1:0] match_vec;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    // the update waits until the response register is free
    assign commit    = (state_reg == S_EVAL) && (!rsp_valid_reg || rsp_ready);

    // -------------------------------------------------------------------
    // Cell row. Each cell sees its left and right neighbor; the ends get
    // constant boundaries (left of cell 0 is "below everything").
    // -------------------------------------------------------------------
    assign cell_ctrl.capture = req_fire;
    assign cell_ctrl.ins_en  = commit && do_ins;
    assign cell_ctrl.rem_en  = commit && do_rem;
    assign cell_ctrl.cmp_key = key;
    assign cell_ctrl.wr_key  = key_reg;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_W-1:0] l_entry;
        logic [KEY_W-1:0] r_entry;
        cell_flags_t      l_flags;

        if (i == 0)
        begin : g_first
            assign l_entry = '0;
            assign l_flags = '{below: 1'b1, ge: 1'b0, match: 1'b0, tail: 1'b0};
        end
        else
        begin : g_mid
            assign l_entry = entries[i-1];
            assign l_flags = cflags[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign r_entry = '0;
        end
        else
        begin : g_next
            assign r_entry = entries[i+1];
        end

        ose_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .count       (count_reg),
            .left_entry  (l_entry),
            .left_flags  (l_flags),
            .right_entry (r_entry),
            .entry       (entries[i]),
            .flags       (cflags[i]),
            .tail_value  (tail_vals[i])
        );

        assign match_vec[i] = cflags[i].match;
    end

    // largest value: only the last occupied cell drives a nonzero tail value
    always_comb
    begin
        tail_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail_or = tail_or | tail_vals[i];
        end
    end

    assign found    = |match_vec;
    assign is_full  = (count_reg == CAP_C);
    assign is_empty = (count_reg == '0);
    assign do_ins   = (func_reg == FUNC_INSERT) && !found && !is_full;
    assign do_rem   = (func_reg == FUNC_REMOVE) && found;

    // -------------------------------------------------------------------
    // Result and count update, evaluated in EVAL.
    // -------------------------------------------------------------------
    always_comb
    begin
        hit_next       = 1'b0;
        value_next     = '0;
        full_err_next  = 1'b0;
        empty_err_next = 1'b0;
        count_next     = count_reg;
        case (func_reg)
            FUNC_INSERT:
            begin
                hit_next      = do_ins;
                full_err_next = !found && is_full;
                if (do_ins)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            FUNC_REMOVE:
            begin
                hit_next = do_rem;
                if (do_rem)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            FUNC_CONTAINS:
            begin
                hit_next = found;
            end
            FUNC_MIN:
            begin
                empty_err_next = is_empty;
                value_next     = is_empty ? '0 : entries[0];
            end
            FUNC_MAX:
            begin
                empty_err_next = is_empty;
                value_next     = tail_or;
            end
            FUNC_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                // unused codes: no operation, count reported unchanged
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (commit)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    // request and response payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            func_reg <= func;
            key_reg  <= key;
        end
        if (commit)
        begin
            hit_reg       <= hit_next;
            value_reg     <= value_next;
            rcount_reg    <= count_next;
            full_err_reg  <= full_err_next;
            empty_err_reg <= empty_err_next;
        end
    end

    // entry_count is the count masked to its port width
    logic [CW+CNT_OUT_W-1:0] rcount_ext;
    assign rcount_ext = {{CNT_OUT_W{1'b0}}, rcount_reg};

    assign rsp_valid    = rsp_valid_reg;
    assign hit          = hit_reg;
    assign result_value = value_reg;
    assign entry_count  = rcount_ext[CNT_OUT_W-1:0];
    assign full_error   = full_err_reg;
    assign empty_error  = empty_err_reg;

    // -------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("stored count above capacity");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && do_ins) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the count by one");

    a_hit_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(hit && full_error))
        else $error("response flags both hit and full");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && rsp_valid_reg && !rsp_ready) |=>
            (state_reg == S_EVAL && $stable(count_reg)))
        else $error("update committed over a pending response");

endmodule
